/* rtl/lcsdt_pkg.sv */
// Shared types, codes and defaults for the LCS length and direction table unit.
// No dependencies; imported by every module of the block.
package lcsdt_pkg;

    localparam int MAX_LEN_DEF = 64;

    typedef logic [2:0] t_mode;
    typedef logic [1:0] t_dir;
    typedef logic [1:0] t_status;

    // request modes
    localparam t_mode MODE_CLEAR = 3'd0;
    localparam t_mode MODE_APP1  = 3'd1;
    localparam t_mode MODE_APP2  = 3'd2;
    localparam t_mode MODE_COMP  = 3'd3;
    localparam t_mode MODE_READ  = 3'd4;

    // direction codes
    localparam t_dir DIR_DIAG = 2'd0;
    localparam t_dir DIR_LEFT = 2'd1;
    localparam t_dir DIR_UP   = 2'd2;
    localparam t_dir DIR_TIE  = 2'd3;

    // status codes
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_RANGE   = 2'd2;
    localparam t_status ST_NOTABLE = 2'd3;

endpackage

/* rtl/lcsdt_cell.sv */
// Shared cell evaluator: symbol compare, score compare and select for one table cell.
// Depends on lcsdt_pkg.
module lcsdt_cell #(
    parameter int SW = 7
) (
    input  logic [7:0]        i_sym_a,
    input  logic [7:0]        i_sym_b,
    input  logic [SW-1:0]     i_diag,
    input  logic [SW-1:0]     i_left,
    input  logic [SW-1:0]     i_up,
    output logic [SW-1:0]     o_val,
    output lcsdt_pkg::t_dir   o_code
);
    import lcsdt_pkg::*;

    always_comb begin
        if (i_sym_a == i_sym_b) begin
            o_val  = i_diag + SW'(1);
            o_code = DIR_DIAG;
        end else if (i_left > i_up) begin
            o_val  = i_left;
            o_code = DIR_LEFT;
        end else if (i_left < i_up) begin
            o_val  = i_up;
            o_code = DIR_UP;
        end else begin
            o_val  = i_left;
            o_code = DIR_TIE;
        end
    end

endmodule

/* rtl/lcs_length_and_direction_table_unit.sv */
// Top level: request decode, cell sequencer, string, score and direction memories.
// Depends on lcsdt_pkg and lcsdt_cell.
// Request flow: clear and append answer from the output register, a direction read via S_DREAD,
// a compute via S_ROW per row and S_RD, S_CALC per cell, or at once with an empty string.
// Throughput: one request a cycle for clear/append while results are taken.
// Reset: synchronous active low; lengths, table flag, last length cleared, no sweep.
module lcs_length_and_direction_table_unit #(
    parameter int MAX_LEN = lcsdt_pkg::MAX_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  lcsdt_pkg::t_mode     i_mode,
    input  logic [7:0]           i_symbol,
    input  logic [5:0]           i_row,
    input  logic [5:0]           i_col,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [6:0]           o_lcs_length,
    output lcsdt_pkg::t_dir      o_direction,
    output lcsdt_pkg::t_status   o_status
);
    import lcsdt_pkg::*;

    // IW indexes one string position, LW holds a length or a score (0..MAX_LEN)
    localparam int IW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int DW     = 2 * IW;
    localparam int DDEPTH = 1 << DW;
    localparam int CW     = (LW > 6) ? LW : 6;
    localparam int OW     = (LW > 7) ? LW : 7;
    localparam int XW     = IW + 6;
    localparam logic [LW-1:0] FULL_LEN = LW'(MAX_LEN);

    // S_ROW fetches the first-string symbol of a row; S_RD fetches the
    // second-string symbol and the upper score; S_CALC evaluates and writes back.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DREAD,
        S_ROW,
        S_RD,
        S_CALC
    } t_state;

    t_state         r_state, n_state;
    logic [LW-1:0]  r_len1, n_len1;
    logic [LW-1:0]  r_len2, n_len2;
    logic           r_tvalid, n_tvalid;
    logic [LW-1:0]  r_last, n_last;
    logic [IW-1:0]  r_i, n_i;
    logic [IW-1:0]  r_j, n_j;
    logic [LW-1:0]  r_left, n_left;
    logic [LW-1:0]  r_diag, n_diag;
    logic           r_o_valid, n_o_valid;
    logic [6:0]     r_o_len, n_o_len;
    t_dir           r_o_dir, n_o_dir;
    t_status        r_o_status, n_o_status;

    // memories and their registered read data
    logic [7:0]     m_first  [MAX_LEN];
    logic [7:0]     m_second [MAX_LEN];
    logic [LW-1:0]  m_score  [MAX_LEN+1];
    t_dir           m_dir    [DDEPTH];
    logic [7:0]     r_a_q;
    logic [7:0]     r_b_q;
    logic [LW-1:0]  r_up_q;
    t_dir           r_dq;

    logic           w_accept;
    logic           w_full1, w_full2;
    logic           w_range;
    logic           w_j_last, w_i_last;
    logic [LW-1:0]  w_sidx;
    logic [LW-1:0]  w_up;
    logic [LW-1:0]  w_val;
    t_dir           w_code;
    logic [XW-1:0]  w_row_x, w_col_x;
    logic [DW-1:0]  w_rd_addr, w_wr_addr;

    function automatic logic [6:0] f_len7(input logic [LW-1:0] v);
        logic [OW-1:0] t;
        t = OW'(v);
        return t[6:0];
    endfunction

    // a new request waits for the sequencer and a free output register
    assign o_ready  = (r_state == S_IDLE) && (!r_o_valid || i_ready);
    assign w_accept = i_valid && o_ready;

    assign w_full1 = (r_len1 >= FULL_LEN);
    assign w_full2 = (r_len2 >= FULL_LEN);
    assign w_range = (CW'(i_row) >= CW'(r_len1)) || (CW'(i_col) >= CW'(r_len2));

    assign w_j_last = (LW'(r_j) == (r_len2 - LW'(1)));
    assign w_i_last = (LW'(r_i) == (r_len1 - LW'(1)));
    assign w_sidx   = LW'(r_j) + LW'(1);
    // first row sees an all-zero row above it, so the score row needs no clearing
    assign w_up     = (r_i == '0) ? '0 : r_up_q;

    assign w_row_x   = XW'(i_row);
    assign w_col_x   = XW'(i_col);
    assign w_rd_addr = {w_row_x[IW-1:0], w_col_x[IW-1:0]};
    assign w_wr_addr = {r_i, r_j};

    lcsdt_cell #(
        .SW (LW)
    ) u_cell (
        .i_sym_a (r_a_q),
        .i_sym_b (r_b_q),
        .i_diag  (r_diag),
        .i_left  (r_left),
        .i_up    (w_up),
        .o_val   (w_val),
        .o_code  (w_code)
    );

    // string memories: append writes, one sequencer read each
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == MODE_APP1) && !w_full1) begin
            m_first[r_len1[IW-1:0]] <= i_symbol;
        end
        if (r_state == S_ROW) begin
            r_a_q <= m_first[r_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == MODE_APP2) && !w_full2) begin
            m_second[r_len2[IW-1:0]] <= i_symbol;
        end
        if (r_state == S_RD) begin
            r_b_q <= m_second[r_j];
        end
    end

    // score row: read upper score at j+1, write the new score back there
    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            m_score[w_sidx] <= w_val;
        end
        if (r_state == S_RD) begin
            r_up_q <= m_score[w_sidx];
        end
    end

    // direction table, row-major with a power-of-two row pitch
    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            m_dir[w_wr_addr] <= w_code;
        end
        if (w_accept && (i_mode == MODE_READ)) begin
            r_dq <= m_dir[w_rd_addr];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_len1     = r_len1;
        n_len2     = r_len2;
        n_tvalid   = r_tvalid;
        n_last     = r_last;
        n_i        = r_i;
        n_j        = r_j;
        n_left     = r_left;
        n_diag     = r_diag;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_len    = r_o_len;
        n_o_dir    = r_o_dir;
        n_o_status = r_o_status;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_o_valid  = 1'b1;
                    n_o_len    = f_len7(r_last);
                    n_o_dir    = DIR_DIAG;
                    n_o_status = ST_OK;
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_len1   = '0;
                            n_len2   = '0;
                            n_tvalid = 1'b0;
                        end
                        MODE_APP1: begin
                            if (w_full1) begin
                                n_o_status = ST_FULL;
                            end else begin
                                n_len1   = r_len1 + LW'(1);
                                n_tvalid = 1'b0;
                            end
                        end
                        MODE_APP2: begin
                            if (w_full2) begin
                                n_o_status = ST_FULL;
                            end else begin
                                n_len2   = r_len2 + LW'(1);
                                n_tvalid = 1'b0;
                            end
                        end
                        MODE_COMP: begin
                            if ((r_len1 == '0) || (r_len2 == '0)) begin
                                n_last   = '0;
                                n_tvalid = 1'b1;
                                n_o_len  = '0;
                            end else begin
                                n_o_valid = 1'b0;
                                n_i       = '0;
                                n_state   = S_ROW;
                            end
                        end
                        MODE_READ: begin
                            if (!r_tvalid) begin
                                n_o_status = ST_NOTABLE;
                            end else if (w_range) begin
                                n_o_status = ST_RANGE;
                            end else begin
                                n_o_valid = 1'b0;
                                n_state   = S_DREAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DREAD: begin
                n_o_valid  = 1'b1;
                n_o_len    = f_len7(r_last);
                n_o_dir    = r_dq;
                n_o_status = ST_OK;
                n_state    = S_IDLE;
            end
            S_ROW: begin
                n_j     = '0;
                n_left  = '0;
                n_diag  = '0;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                n_left = w_val;
                n_diag = w_up;
                if (!w_j_last) begin
                    n_j     = r_j + IW'(1);
                    n_state = S_RD;
                end else if (!w_i_last) begin
                    n_i     = r_i + IW'(1);
                    n_state = S_ROW;
                end else begin
                    n_last     = w_val;
                    n_tvalid   = 1'b1;
                    n_o_valid  = 1'b1;
                    n_o_len    = f_len7(w_val);
                    n_o_dir    = DIR_DIAG;
                    n_o_status = ST_OK;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len1    <= '0;
            r_len2    <= '0;
            r_tvalid  <= 1'b0;
            r_last    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len1    <= n_len1;
            r_len2    <= n_len2;
            r_tvalid  <= n_tvalid;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_left     <= n_left;
        r_diag     <= n_diag;
        r_o_len    <= n_o_len;
        r_o_dir    <= n_o_dir;
        r_o_status <= n_o_status;
    end

    assign o_valid      = r_o_valid;
    assign o_lcs_length = r_o_len;
    assign o_direction  = r_o_dir;
    assign o_status     = r_o_status;

endmodule

/* rtl/lcsdt_chk.sv */
// Port-level checker for the LCS length and direction table unit, with its bind.
// Depends on lcsdt_pkg and lcs_length_and_direction_table_unit.
module lcsdt_chk #(
    parameter int MAX_LEN = lcsdt_pkg::MAX_LEN_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input lcsdt_pkg::t_mode     i_mode,
    input logic [7:0]           i_symbol,
    input logic [5:0]           i_row,
    input logic [5:0]           i_col,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [6:0]           o_lcs_length,
    input lcsdt_pkg::t_dir      o_direction,
    input lcsdt_pkg::t_status   o_status
);
    import lcsdt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_lcs_length)
            && $stable(o_direction) && $stable(o_status))
        else $error("result changed while stalled");

    // no new request while the output register is blocked
    a_no_accept_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while result blocked");

    // any failing status reports direction zero
    a_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_direction == DIR_DIAG)
        else $error("direction set on a failed request");

    // clear and append answer in the next cycle, never with a read status
    a_append_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && ((i_mode == MODE_CLEAR) || (i_mode == MODE_APP1)
            || (i_mode == MODE_APP2))
        |=> o_valid && (o_status != ST_RANGE) && (o_status != ST_NOTABLE))
        else $error("clear or append answered wrongly");

    // score never exceeds the string limit
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (MAX_LEN > 127) || (int'(o_lcs_length) <= MAX_LEN))
        else $error("length beyond string limit");

endmodule

bind lcs_length_and_direction_table_unit lcsdt_chk #(.MAX_LEN(MAX_LEN)) u_lcsdt_chk (.*);

/* test/lcs_length_and_direction_table_unit_test.sv */
// Self-checking testbench for lcs_length_and_direction_table_unit: a directed table of requests,
// then random string loads, computes and direction reads, all checked by an in-bench LCS model.
// Depends on lcsdt_pkg and the unit itself.
module lcs_length_and_direction_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcsdt_pkg::*;

    localparam int MAX_LEN        = MAX_LEN_DEF;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 850;
    localparam int QUIET_ITEMS    = 120;     // final stretch with no idling on either side
    localparam int TAIL_CYCLES    = 20;
    localparam int TIMEOUT_CYCLES = 2_000_000;

    // modes the unit must ignore
    localparam t_mode MODE_SPARE_LO  = 3'd5;
    localparam t_mode MODE_SPARE_MID = 3'd6;
    localparam t_mode MODE_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [6:0] len;
        t_dir       dir;
        t_status    st;
    } t_lcs_result;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  symbol;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        typed;    // expected result below is used instead of the model's
        t_lcs_result want;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 24;

    // first string 00 FF 41, second string FF 41 00: longest common subsequence is two
    localparam t_directed_row DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_READ,      8'h00, 6'd0,  6'd0,  1'b1, '{7'd0, DIR_DIAG, ST_NOTABLE}},
        '{MODE_COMP,      8'h00, 6'd0,  6'd0,  1'b1, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_READ,      8'h00, 6'd0,  6'd0,  1'b1, '{7'd0, DIR_DIAG, ST_RANGE}},
        '{MODE_SPARE_LO,  8'hFF, 6'd63, 6'd63, 1'b1, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_SPARE_HI,  8'hFF, 6'd63, 6'd63, 1'b1, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_APP1,      8'h00, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_APP1,      8'hFF, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_APP1,      8'h41, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_APP2,      8'hFF, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_APP2,      8'h41, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_APP2,      8'h00, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_READ,      8'h00, 6'd0,  6'd0,  1'b1, '{7'd0, DIR_DIAG, ST_NOTABLE}},
        '{MODE_COMP,      8'h00, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_READ,      8'h00, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_READ,      8'h00, 6'd1,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_READ,      8'h00, 6'd2,  6'd1,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_READ,      8'h00, 6'd2,  6'd2,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        '{MODE_READ,      8'h00, 6'd3,  6'd0,  1'b1, '{7'd2, DIR_DIAG, ST_RANGE}},
        '{MODE_READ,      8'h00, 6'd0,  6'd63, 1'b1, '{7'd2, DIR_DIAG, ST_RANGE}},
        '{MODE_SPARE_MID, 8'h5A, 6'd21, 6'd42, 1'b1, '{7'd2, DIR_DIAG, ST_OK}},
        '{MODE_CLEAR,     8'h00, 6'd0,  6'd0,  1'b1, '{7'd2, DIR_DIAG, ST_OK}},
        '{MODE_READ,      8'h00, 6'd0,  6'd0,  1'b1, '{7'd2, DIR_DIAG, ST_NOTABLE}},
        '{MODE_APP1,      8'h55, 6'd0,  6'd0,  1'b0, '{7'd0, DIR_DIAG, ST_OK}},
        // second string empty: length drops to zero, table valid but nothing readable
        '{MODE_COMP,      8'h00, 6'd0,  6'd0,  1'b1, '{7'd0, DIR_DIAG, ST_OK}}
    };

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       i_valid  = 1'b0;
    t_mode      i_mode   = MODE_CLEAR;
    logic [7:0] i_symbol = 8'h00;
    logic [5:0] i_row    = 6'd0;
    logic [5:0] i_col    = 6'd0;
    logic       i_ready  = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [6:0] o_lcs_length;
    t_dir       o_direction;
    t_status    o_status;

    lcs_length_and_direction_table_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_symbol     (i_symbol),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_lcs_length (o_lcs_length),
        .o_direction  (o_direction),
        .o_status     (o_status)
    );

    // ---------------------------------------------------------------------------------
    // Mirror of the unit's state: both strings, their lengths, the direction table,
    // the table-valid flag and the length from the last compute.
    // ---------------------------------------------------------------------------------
    logic [7:0] first_str  [MAX_LEN];
    logic [7:0] second_str [MAX_LEN];
    int         first_len;
    int         second_len;
    t_dir       dir_table  [MAX_LEN][MAX_LEN];
    bit         table_ok;
    int         last_len;

    t_lcs_result expected_results [$];
    int          mismatch_count  = 0;
    int          requests_sent   = 0;

    // idling knobs, in percent per request / per cycle
    bit idle_on        = 1'b1;
    int send_gap_pct   = 0;
    int ready_stall_pct = 0;

    // Applies one request to the mirror and returns the result it should produce.
    function automatic t_lcs_result predict_lcs(input t_mode mode, input logic [7:0] symbol,
                                                input logic [5:0] row, input logic [5:0] col);
        t_lcs_result res;
        int          score [MAX_LEN + 1];
        int          corner;
        int          up_score;
        int          left_score;
        res.dir = DIR_DIAG;
        res.st  = ST_OK;
        case (mode)
            MODE_CLEAR: begin
                first_len  = 0;
                second_len = 0;
                table_ok   = 1'b0;
            end
            MODE_APP1: begin
                if (first_len >= MAX_LEN) begin
                    res.st = ST_FULL;
                end else begin
                    first_str[first_len] = symbol;
                    first_len++;
                    table_ok = 1'b0;
                end
            end
            MODE_APP2: begin
                if (second_len >= MAX_LEN) begin
                    res.st = ST_FULL;
                end else begin
                    second_str[second_len] = symbol;
                    second_len++;
                    table_ok = 1'b0;
                end
            end
            MODE_COMP: begin
                // single rolling row of scores; corner holds the old value up and left
                for (int j = 0; j <= second_len; j++) score[j] = 0;
                for (int i = 0; i < first_len; i++) begin
                    corner   = 0;
                    score[0] = 0;
                    for (int j = 0; j < second_len; j++) begin
                        up_score   = score[j + 1];
                        left_score = score[j];
                        if (first_str[i] == second_str[j]) begin
                            score[j + 1]    = corner + 1;
                            dir_table[i][j] = DIR_DIAG;
                        end else if (left_score > up_score) begin
                            dir_table[i][j] = DIR_LEFT;
                            score[j + 1]    = left_score;
                        end else if (left_score < up_score) begin
                            dir_table[i][j] = DIR_UP;
                        end else begin
                            dir_table[i][j] = DIR_TIE;
                            score[j + 1]    = left_score;
                        end
                        corner = up_score;
                    end
                end
                last_len = score[second_len];
                table_ok = 1'b1;
            end
            MODE_READ: begin
                if (!table_ok)
                    res.st = ST_NOTABLE;
                else if (row >= first_len || col >= second_len)
                    res.st = ST_RANGE;
                else
                    res.dir = dir_table[row][col];
            end
            default: ;
        endcase
        res.len = last_len[6:0];
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // Clock and timeout
    // ---------------------------------------------------------------------------------
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------------------------
    // Result side: ready drops in random bursts, changed at the falling edge so it is
    // stable at the sampling edge.
    // ---------------------------------------------------------------------------------
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 99) < ready_stall_pct) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(1, 15) - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // every accepted result is matched against the oldest outstanding expectation
    always @(posedge i_clk) begin : check_results
        t_lcs_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: length %0d, direction %0d, status %0d",
                         $time, o_lcs_length, o_direction, o_status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_lcs_length !== want.len) begin
                    $display("%0t: length expected %0d, got %0d", $time, want.len,
                             o_lcs_length);
                    mismatch_count++;
                end
                if (o_direction !== want.dir) begin
                    $display("%0t: direction expected %0d, got %0d", $time, want.dir,
                             o_direction);
                    mismatch_count++;
                end
                if (o_status !== want.st) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.st, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------------------

    // Drives one request at the falling edge, holds it until accepted, then records the
    // expectation. A typed result overrides the mirror's, which is still updated.
    task automatic send_request(input t_mode mode, input logic [7:0] symbol,
                                input logic [5:0] row, input logic [5:0] col,
                                input bit typed = 1'b0,
                                input t_lcs_result typed_want = '0);
        int          gap;
        t_lcs_result res;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < send_gap_pct)
            gap = $urandom_range(1, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_mode   <= mode;
        i_symbol <= symbol;
        i_row    <= row;
        i_col    <= col;
        do @(posedge i_clk); while (!o_ready);
        res = predict_lcs(mode, symbol, row, col);
        expected_results.push_back(typed ? typed_want : res);
        requests_sent++;
    endtask

    // hold off new requests until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // direction read, mostly inside the computed extent
    task automatic read_cell();
        logic [5:0] row;
        logic [5:0] col;
        if (first_len > 0 && second_len > 0 && $urandom_range(0, 99) < 85) begin
            row = 6'($urandom_range(0, first_len - 1));
            col = 6'($urandom_range(0, second_len - 1));
        end else begin
            row = 6'($urandom_range(0, 63));
            col = 6'($urandom_range(0, 63));
        end
        send_request(MODE_READ, 8'($urandom_range(0, 255)), row, col);
    endtask

    // Mostly well-formed run: clear, load both strings interleaved, compute, read back cells.
    // Symbols mostly come from a narrow window of the alphabet so matches are common.
    task automatic run_lcs_sequence(input bit full_size);
        int len_a;
        int len_b;
        int spread;
        int base;
        int n_reads;
        case ($urandom_range(0, 3))
            0:       spread = 2;
            1:       spread = 4;
            2:       spread = 8;
            default: spread = 256;
        endcase
        base = $urandom_range(0, 255);
        if (full_size) begin
            len_a = MAX_LEN + $urandom_range(1, 3);    // the extra appends hit a full string
            len_b = MAX_LEN + $urandom_range(1, 3);
        end else begin
            len_a = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
            len_b = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
        end
        if ($urandom_range(0, 9) != 0)
            send_request(MODE_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
        while (len_a > 0 || len_b > 0) begin
            if (len_b == 0 || (len_a > 0 && $urandom_range(0, 1) == 0)) begin
                send_request(MODE_APP1, 8'(base + $urandom_range(0, spread - 1)),
                             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
                len_a--;
            end else begin
                send_request(MODE_APP2, 8'(base + $urandom_range(0, spread - 1)),
                             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
                len_b--;
            end
        end
        // a skipped compute leaves reads facing a stale table
        if ($urandom_range(0, 9) != 0)
            send_request(MODE_COMP, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
        n_reads = full_size ? 12 : $urandom_range(1, 6);
        repeat (n_reads) read_cell();
    endtask

    // loose requests of any mode; large computes are steered to reads to bound run time
    task automatic send_noise(input int count);
        t_mode mode;
        repeat (count) begin
            mode = t_mode'($urandom_range(0, 7));
            if (mode == MODE_COMP && first_len * second_len > 256)
                mode = MODE_READ;
            send_request(mode, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
        end
    endtask

    // random idling mix for the next stretch; zero leaves a side busy throughout
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    initial begin : stimulus
        bit first_run;
        first_len  = 0;
        second_len = 0;
        table_ok   = 1'b0;
        last_len   = 0;
        first_run  = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        send_gap_pct    = pick_idle_pct();
        ready_stall_pct = pick_idle_pct();
        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_request(DIRECTED[k].mode, DIRECTED[k].symbol, DIRECTED[k].row,
                         DIRECTED[k].col, DIRECTED[k].typed, DIRECTED[k].want);
        drain_results();

        // random part: mostly complete load/compute/read runs, some loose requests
        while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            if (requests_sent >= DIRECTED_ROWS + RANDOM_ITEMS - QUIET_ITEMS) begin
                idle_on = 1'b0;
            end else begin
                send_gap_pct    = pick_idle_pct();
                ready_stall_pct = pick_idle_pct();
            end
            if (first_run || $urandom_range(0, 29) == 0)
                run_lcs_sequence(1'b1);
            else if ($urandom_range(0, 4) == 0)
                send_noise($urandom_range(1, 6));
            else
                run_lcs_sequence(1'b0);
            first_run = 1'b0;
            if (idle_on && $urandom_range(0, 9) == 0)
                drain_results();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            mismatch_count++;

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
